@@ sv/servo_pulse_step_accel_limit_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SERVO_PULSE_STEP_ACCEL_LIMIT_CORE_DEFINES_SVH
`define SERVO_PULSE_STEP_ACCEL_LIMIT_CORE_DEFINES_SVH

// Checked at every edge outside reset.
`define SPSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/spsa_pkg.sv @@
package spsa_pkg;

   localparam int AXES_DEFAULT      = 6;
   localparam int POS_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSES       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSES       = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_STEP_LIMIT = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_PULSES      = 8'd3;

   localparam logic [15:0] MIN_PULSES_RESET       = 16'd0;
   localparam logic [15:0] MAX_PULSES_RESET       = 16'd1000;
   localparam logic [15:0] ACCEL_STEP_LIMIT_RESET = 16'd100;
   localparam logic [15:0] HOME_PULSES_RESET      = 16'd100;

   localparam logic OP_NORMAL = 1'b0;
   localparam logic OP_HOME   = 1'b1;

   typedef struct packed {
      logic               op;
      logic [2:0]         axis;
      logic               lower_limit;
      logic [15:0]        pulses_left;
      logic signed [31:0] target_position;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_axis;
      logic [15:0]        pulse_count;
      logic               direction_up;
      logic signed [31:0] position;
   } rsp_type;

endpackage

@@ sv/servo_pulse_step_accel_limit_core.sv @@
// Flow: an accepted item sits in the input register, then its result is loaded into the
// result register and shown on rsp; it waits longer while rsp_stall holds.
// Throughput: one item per cycle unless rsp_stall holds a waiting result; the per-axis
// state update and the result register load happen at the same edge, so items for one axis may follow back to back.
// Reset (synchronous, active high) empties both stages, zeroes all axis state
// and loads the register defaults.
module servo_pulse_step_accel_limit_core #(
   parameter int AXES      = spsa_pkg::AXES_DEFAULT,
   parameter int POS_WIDTH = spsa_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  spsa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spsa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spsa_pkg::CSR_DATA_W-1:0]     csr_data
);
   import spsa_pkg::*;

   localparam int P  = POS_WIDTH;
   localparam int W  = ((P > 32) ? P : 32) + 4;
   localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic signed [W-1:0] POS_HI = {{(W-P+1){1'b0}}, {(P-1){1'b1}}};
   localparam logic signed [W-1:0] POS_LO = ~POS_HI;

   function automatic logic signed [W-1:0] clamp_pos(input logic signed [W-1:0] v);
      logic signed [W-1:0] r;
      r = v;
      if (v > POS_HI) begin
         r = POS_HI;
      end else if (v < POS_LO) begin
         r = POS_LO;
      end
      return r;
   endfunction

   logic [15:0] min_pulses_ff, max_pulses_ff, accel_limit_ff, home_pulses_ff;

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic signed [P-1:0] axis_position_ff  [AXES];
   logic signed [P-1:0] prior_position_ff [AXES];
   logic signed [P-1:0] history_position_ff [AXES];
   logic                last_direction_ff [AXES];

   logic                move;
   logic [IW+2:0]       axis_ext;
   logic [IW-1:0]       idx;
   logic                in_range;
   logic signed [W-1:0] pos_old, prior_old, left_w, tgt_w, corr, accel, lim_w;
   logic signed [W-1:0] distance, mag, max_w, min_w, cnt_w, new_pos, home_pos;
   logic                up;
   logic [15:0]         count;
   rsp_type             rsp_data_in;

   assign move      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      axis_ext  = {{IW{1'b0}}, in_data_ff.axis};
      idx       = axis_ext[IW-1:0];
      in_range  = (axis_ext < (IW+3)'(AXES));
      pos_old   = {{(W-P){axis_position_ff[idx][P-1]}}, axis_position_ff[idx]};
      prior_old = {{(W-P){prior_position_ff[idx][P-1]}}, prior_position_ff[idx]};
      left_w    = {{(W-16){1'b0}}, in_data_ff.pulses_left};
      tgt_w     = {{(W-32){in_data_ff.target_position[31]}}, in_data_ff.target_position};
      lim_w     = {{(W-16){1'b0}}, accel_limit_ff};
      max_w     = {{(W-16){1'b0}}, max_pulses_ff};
      min_w     = {{(W-16){1'b0}}, min_pulses_ff};

      if (in_data_ff.lower_limit) begin
         corr = '0;
      end else if (last_direction_ff[idx]) begin
         corr = clamp_pos(pos_old - left_w);
      end else begin
         corr = clamp_pos(pos_old + left_w);
      end

      accel = tgt_w - (corr <<< 1) + prior_old;
      if (accel > lim_w) begin
         accel = lim_w;
      end else if (accel < -lim_w) begin
         accel = -lim_w;
      end

      distance = corr - prior_old + accel;
      up       = !distance[W-1];
      mag      = up ? distance : -distance;
      count = (mag > max_w) ? max_pulses_ff : mag[15:0];
      if (mag < min_w) begin
         count = '0;
      end
      cnt_w   = {{(W-16){1'b0}}, count};
      new_pos = up ? clamp_pos(corr + cnt_w) : clamp_pos(corr - cnt_w);

      home_pos = in_data_ff.lower_limit ? '0 : pos_old;

      rsp_data_in.out_axis     = in_data_ff.axis;
      rsp_data_in.pulse_count  = '0;
      rsp_data_in.direction_up = 1'b0;
      rsp_data_in.position     = '0;
      if (in_range) begin
         if (in_data_ff.op == OP_HOME) begin
            rsp_data_in.pulse_count = home_pulses_ff;
            rsp_data_in.position    = home_pos[31:0];
         end else begin
            rsp_data_in.pulse_count  = count;
            rsp_data_in.direction_up = up;
            rsp_data_in.position     = new_pos[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulses_ff  <= MIN_PULSES_RESET;
         max_pulses_ff  <= MAX_PULSES_RESET;
         accel_limit_ff <= ACCEL_STEP_LIMIT_RESET;
         home_pulses_ff <= HOME_PULSES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_PULSES:       min_pulses_ff  <= csr_data;
            CSR_MAX_PULSES:       max_pulses_ff  <= csr_data;
            CSR_ACCEL_STEP_LIMIT: accel_limit_ff <= csr_data;
            CSR_HOME_PULSES:      home_pulses_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            axis_position_ff[i]    <= '0;
            prior_position_ff[i]   <= '0;
            history_position_ff[i] <= '0;
            last_direction_ff[i]   <= 1'b0;
         end
      end else if (move && in_range) begin
         if (in_data_ff.op == OP_HOME) begin
            axis_position_ff[idx]    <= home_pos[P-1:0];
            prior_position_ff[idx]   <= '0;
            history_position_ff[idx] <= '0;
            last_direction_ff[idx]   <= 1'b0;
         end else begin
            axis_position_ff[idx]    <= new_pos[P-1:0];
            prior_position_ff[idx]   <= corr[P-1:0];
            history_position_ff[idx] <= prior_old[P-1:0];
            last_direction_ff[idx]   <= up;
         end
      end
   end

endmodule

@@ sv/spsa_checker.sv @@
`include "servo_pulse_step_accel_limit_core_defines.svh"

module spsa_checker #(
   parameter int AXES = spsa_pkg::AXES_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input spsa_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input spsa_pkg::rsp_type                rsp_data,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [spsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [spsa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import spsa_pkg::*;

   `SPSA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "not empty after reset")

   `SPSA_ASSERT(a_stall_only_when_blocked, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req stalled while result path free")

   `SPSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled item changed")

   `SPSA_ASSERT(a_bad_axis_zero, clock, reset, rsp_valid && (32'(rsp_data.out_axis) >= AXES) |-> rsp_data.pulse_count == '0 && !rsp_data.direction_up && rsp_data.position == '0, "bad axis gave a move")

endmodule

bind servo_pulse_step_accel_limit_core spsa_checker #(.AXES(AXES)) u_spsa_checker (.*);
